>>> src/hacl_pkg.sv
// Shared types and constants for the HCI ACL connection credit tracker.
`timescale 1ns / 1ps
package hacl_pkg;

  // Field widths
  localparam int CMD_W      = 4;
  localparam int STATUS_W   = 8;
  localparam int HANDLE_W   = 12;
  localparam int FLAGS_W    = 2;
  localparam int AMOUNT_W   = 16;
  localparam int MODE_W     = 3;
  localparam int CLIMIT_W   = 16;
  localparam int LELIMIT_W  = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int ISSUE_W    = 3;
  localparam int KIND_W     = 2;

  // APB register map
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Queue depths (front-to-back queue, result queue)
  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int RESULT_DEPTH_DEF = 2;

  // Reset values and protocol constants
  localparam logic signed [MODE_W-1:0] HOST_MODE_RESET = 3'sd1;
  localparam logic signed [MODE_W-1:0] HOST_MODE_OFF   = -3'sd1;
  localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RESET   = 16'd1000;
  localparam logic [AMOUNT_W-1:0]      END_FLAG        = 16'h2000;
  localparam logic [AMOUNT_W-1:0]      RX_HDR_BYTES    = 16'd4;
  localparam logic [AMOUNT_W-1:0]      COUNT_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_HOST_MODE     = 2'd0,
    REG_CLASSIC_LIMIT = 2'd1,
    REG_LE_LIMIT      = 2'd2,
    REG_TIMEOUT       = 2'd3
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    OP_CONN_REQ      = 4'd0,
    OP_CLASSIC_DONE  = 4'd1,
    OP_LE_DONE       = 4'd2,
    OP_DISC_DONE     = 4'd3,
    OP_COMPLETED     = 4'd4,
    OP_SEND          = 4'd5,
    OP_RECEIVE       = 4'd6,
    OP_LOCAL_DISC    = 4'd7,
    OP_TICK          = 4'd8,
    OP_NONE          = 4'd15
  } op_t;

  typedef enum logic [ISSUE_W-1:0] {
    ISSUE_NONE       = 3'd0,
    ISSUE_ACCEPT     = 3'd1,
    ISSUE_REJECT     = 3'd2,
    ISSUE_DISCONNECT = 3'd3,
    ISSUE_ADVERT     = 3'd4,
    ISSUE_SCAN       = 3'd5,
    ISSUE_RESET      = 3'd6
  } issue_t;

  typedef enum logic [KIND_W-1:0] {
    LINK_NONE    = 2'd0,
    LINK_CLASSIC = 2'd1,
    LINK_LE      = 2'd2
  } link_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic signed [MODE_W-1:0] host_mode;
    logic [CLIMIT_W-1:0]      classic_limit;
    logic [LELIMIT_W-1:0]     le_limit;
    logic [TIMEOUT_W-1:0]     timeout_reload;
  } cfg_t;

  // Classified item between front and back
  typedef struct packed {
    op_t                 op;
    logic                status_ok;
    logic                rx_flags_ok;
    logic [HANDLE_W-1:0] handle;
    logic [AMOUNT_W-1:0] amount;
    logic [AMOUNT_W-1:0] rx_len;
  } item_t;

  // One result beat
  typedef struct packed {
    logic                ok;
    issue_t              issue;
    logic [AMOUNT_W-1:0] acl_header;
    logic [AMOUNT_W-1:0] payload_length;
    logic                is_connected;
    link_t               link_kind;
    logic [AMOUNT_W-1:0] outstanding;
    logic                can_send;
    logic                last;
  } result_t;

endpackage

>>> src/hci_acl_connection_credit_tracker.sv
// Top level of the HCI ACL connection credit tracker.
`timescale 1ns / 1ps
// Usage:
//   Input channel: drive in_* and raise push; a beat is taken at a clock edge
//   with push high and full low. Each beat is one HCI event or host request.
//   Result channel: while empty is low the oldest result is on out_*; it is
//   taken at an edge with pop high. Every input gives one result with
//   out_last set, except a disconnection complete with host mode off, which
//   gives a reset command beat (out_last low) then a scan enable beat.
//   Configuration: APB write, register i at byte address 4*i; pready is tied
//   high and reads return the register value. Write only while idle.
// Path: a taken input is registered in the item queue, runs through the
//   back end and is registered in the result queue before it is on out_*.
// Throughput: one input per cycle while the result queue has room; the
//   two-beat disconnect holds the back end until both beats are written.
//   The back end writes one result beat per cycle into the result queue.
// Reset (rst_n low, synchronous): no link, count zero, timeout at 1000,
//   registers at defaults, both queues empty.
// Stall: when pop is held low the result queue fills, the back end waits,
//   then the item queue fills and full rises; nothing is lost.
module hci_acl_connection_credit_tracker
  import hacl_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  push,
  output logic                  full,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [STATUS_W-1:0]   in_event_status,
  input  logic [HANDLE_W-1:0]   in_link_handle,
  input  logic [FLAGS_W-1:0]    in_boundary_flags,
  input  logic [AMOUNT_W-1:0]   in_amount,
  // result channel
  output logic                  empty,
  input  logic                  pop,
  output logic                  out_ok,
  output logic [ISSUE_W-1:0]    out_issue_command,
  output logic [AMOUNT_W-1:0]   out_acl_header,
  output logic [AMOUNT_W-1:0]   out_payload_length,
  output logic                  out_is_connected,
  output logic [KIND_W-1:0]     out_link_kind,
  output logic [AMOUNT_W-1:0]   out_outstanding,
  output logic                  out_can_send,
  output logic                  out_last,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  item_t    front_item, q_item;
  logic     q_full, q_empty, q_pop;
  logic     res_full, res_push;
  result_t  res_in, res_out;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.host_mode      <= HOST_MODE_RESET;
      cfg_r.classic_limit  <= '0;
      cfg_r.le_limit       <= '0;
      cfg_r.timeout_reload <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HOST_MODE:     cfg_r.host_mode      <= pwdata[MODE_W-1:0];
        REG_CLASSIC_LIMIT: cfg_r.classic_limit  <= pwdata[CLIMIT_W-1:0];
        REG_LE_LIMIT:      cfg_r.le_limit       <= pwdata[LELIMIT_W-1:0];
        REG_TIMEOUT:       cfg_r.timeout_reload <= pwdata[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_HOST_MODE:     prdata = CFG_DATA_W'(cfg_r.host_mode);
      REG_CLASSIC_LIMIT: prdata = CFG_DATA_W'(cfg_r.classic_limit);
      REG_LE_LIMIT:      prdata = CFG_DATA_W'(cfg_r.le_limit);
      REG_TIMEOUT:       prdata = CFG_DATA_W'(cfg_r.timeout_reload);
      default:           prdata = '0;
    endcase
  end

  // Front end and item queue
  hacl_front u_front (
    .in_cmd            (in_cmd),
    .in_event_status   (in_event_status),
    .in_link_handle    (in_link_handle),
    .in_boundary_flags (in_boundary_flags),
    .in_amount         (in_amount),
    .item              (front_item)
  );

  assign full = q_full;

  hacl_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  // Back end
  hacl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (q_item),
    .item_avail (!q_empty),
    .item_pop   (q_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  // Result queue
  hacl_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign out_ok             = res_out.ok;
  assign out_issue_command  = res_out.issue;
  assign out_acl_header     = res_out.acl_header;
  assign out_payload_length = res_out.payload_length;
  assign out_is_connected   = res_out.is_connected;
  assign out_link_kind      = res_out.link_kind;
  assign out_outstanding    = res_out.outstanding;
  assign out_can_send       = res_out.can_send;
  assign out_last           = res_out.last;

endmodule

>>> src/hacl_fifo.sv
// Small register FIFO used for the item queue and the result queue.
`timescale 1ns / 1ps
module hacl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> src/hacl_front.sv
// Front end: classifies an incoming event beat before it is queued.
`timescale 1ns / 1ps
module hacl_front
  import hacl_pkg::*;
(
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [STATUS_W-1:0] in_event_status,
  input  logic [HANDLE_W-1:0] in_link_handle,
  input  logic [FLAGS_W-1:0]  in_boundary_flags,
  input  logic [AMOUNT_W-1:0] in_amount,
  output item_t               item
);

  // Decode and precompute everything that does not depend on link state
  always_comb begin
    item.op          = (in_cmd <= OP_TICK) ? op_t'(in_cmd) : OP_NONE;
    item.status_ok   = (in_event_status == '0);
    // first-fragment / complete boundary codes have bit 1 set
    item.rx_flags_ok = in_boundary_flags[1];
    item.handle      = in_link_handle;
    item.amount      = in_amount;
    item.rx_len      = (in_amount >= RX_HDR_BYTES) ? in_amount - RX_HDR_BYTES : '0;
  end

endmodule

>>> src/hacl_back.sv
// Back end: link state, credit accounting and result generation.
`timescale 1ns / 1ps
module hacl_back
  import hacl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    item_avail,
  output logic    item_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  logic                 connected_r, connected_nxt;
  link_t                link_r, link_nxt;
  logic [HANDLE_W-1:0]  handle_r, handle_nxt;
  logic [AMOUNT_W-1:0]  unacked_r, unacked_nxt;
  logic [TIMEOUT_W-1:0] timeout_r, timeout_nxt;
  logic                 phase_r, phase_nxt;
  logic                 fire, two_beat;

  function automatic logic has_credit(input link_t lk, input logic [AMOUNT_W-1:0] cnt,
                                      input cfg_t c);
    logic res_v;
    res_v = 1'b1;
    if (lk == LINK_CLASSIC && cnt >= c.classic_limit) res_v = 1'b0;
    if (lk == LINK_LE && cnt >= {{(AMOUNT_W-LELIMIT_W){1'b0}}, c.le_limit}) res_v = 1'b0;
    return res_v;
  endfunction

  assign fire     = item_avail && !res_full;
  assign two_beat = (item.op == OP_DISC_DONE) && (cfg.host_mode == HOST_MODE_OFF);
  // second beat of the off-mode disconnect pops the item
  assign item_pop = fire && !(two_beat && !phase_r);
  assign res_push = fire;

  // Execute one item against the link state
  always_comb begin
    connected_nxt      = connected_r;
    link_nxt           = link_r;
    handle_nxt         = handle_r;
    unacked_nxt        = unacked_r;
    timeout_nxt        = timeout_r;
    phase_nxt          = phase_r;
    res.ok             = 1'b0;
    res.issue          = ISSUE_NONE;
    res.acl_header     = '0;
    res.payload_length = '0;
    res.last           = 1'b1;

    case (item.op)
      OP_CONN_REQ: begin
        res.issue = connected_r ? ISSUE_REJECT : ISSUE_ACCEPT;
      end
      OP_CLASSIC_DONE, OP_LE_DONE: begin
        if (item.status_ok && (item.op == OP_CLASSIC_DONE || !connected_r)) begin
          connected_nxt = 1'b1;
          timeout_nxt   = cfg.timeout_reload;
          link_nxt      = (item.op == OP_CLASSIC_DONE) ? LINK_CLASSIC : LINK_LE;
          handle_nxt    = item.handle;
          unacked_nxt   = '0;
        end
      end
      OP_DISC_DONE: begin
        connected_nxt = 1'b0;
        timeout_nxt   = cfg.timeout_reload;
        link_nxt      = LINK_NONE;
        handle_nxt    = '0;
        unacked_nxt   = '0;
        if (two_beat) begin
          res.issue = phase_r ? ISSUE_SCAN : ISSUE_RESET;
          res.last  = phase_r;
          phase_nxt = !phase_r;
        end else begin
          res.issue = (cfg.host_mode > 3'sd0) ? ISSUE_ADVERT : ISSUE_SCAN;
        end
      end
      OP_COMPLETED: begin
        timeout_nxt = cfg.timeout_reload;
        unacked_nxt = (unacked_r > item.amount) ? unacked_r - item.amount : '0;
      end
      OP_SEND: begin
        if (item.amount == '0) begin
          res.ok = 1'b1;
        end else if (connected_r && has_credit(link_r, unacked_r, cfg)) begin
          res.ok         = 1'b1;
          res.acl_header = {{(AMOUNT_W-HANDLE_W){1'b0}}, handle_r} | END_FLAG;
          if (unacked_r != COUNT_MAX) unacked_nxt = unacked_r + 1'b1;
        end
      end
      OP_RECEIVE: begin
        if (item.rx_flags_ok && connected_r && item.handle == handle_r) begin
          res.ok             = 1'b1;
          res.payload_length = item.rx_len;
        end
      end
      OP_LOCAL_DISC: begin
        res.issue     = ISSUE_DISCONNECT;
        connected_nxt = 1'b0;
        timeout_nxt   = cfg.timeout_reload;
        link_nxt      = LINK_NONE;
        handle_nxt    = '0;
      end
      OP_TICK: begin
        if (unacked_r == '0 || !connected_r) begin
          timeout_nxt = cfg.timeout_reload;
        end else if (timeout_r != '0) begin
          timeout_nxt = timeout_r - 1'b1;
          // counter expires: forced local disconnect
          if (timeout_r == TIMEOUT_W'(1)) begin
            res.issue     = ISSUE_DISCONNECT;
            connected_nxt = 1'b0;
            timeout_nxt   = cfg.timeout_reload;
            link_nxt      = LINK_NONE;
            handle_nxt    = '0;
          end
        end
      end
      default: begin
      end
    endcase

    res.is_connected = connected_nxt;
    res.link_kind    = link_nxt;
    res.outstanding  = unacked_nxt;
    res.can_send     = has_credit(link_nxt, unacked_nxt, cfg);
  end

  // Link state registers, updated only when a beat goes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      connected_r <= 1'b0;
      link_r      <= LINK_NONE;
      handle_r    <= '0;
      unacked_r   <= '0;
      timeout_r   <= TIMEOUT_RESET;
      phase_r     <= 1'b0;
    end else if (fire) begin
      connected_r <= connected_nxt;
      link_r      <= link_nxt;
      handle_r    <= handle_nxt;
      unacked_r   <= unacked_nxt;
      timeout_r   <= timeout_nxt;
      phase_r     <= phase_nxt;
    end
  end

endmodule

>>> src/hacl_checker.sv
// Port-level checks for the HCI ACL connection credit tracker.
`timescale 1ns / 1ps
module hacl_checker
  import hacl_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                empty,
  input logic                out_ok,
  input logic [ISSUE_W-1:0]  out_issue_command,
  input logic [AMOUNT_W-1:0] out_acl_header,
  input logic                out_is_connected,
  input logic [KIND_W-1:0]   out_link_kind,
  input logic                out_can_send,
  input logic                out_last
);

  // reset drains the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // only the off-mode disconnect leaves a beat without last
  a_first_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_last |-> out_issue_command == ISSUE_RESET)
    else $error("non-final beat is not a reset command");

  // an accepted send or receive never carries a command
  a_ok_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_ok |-> out_issue_command == ISSUE_NONE)
    else $error("ok beat carries a command");

  // a header goes out only with an accepted send and has the end flag
  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_acl_header != '0 |-> out_ok && out_acl_header[13])
    else $error("bad outbound header");

  // no link means no link type and free credit
  a_idle_link: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_is_connected |-> out_link_kind == LINK_NONE && out_can_send)
    else $error("disconnected beat shows a link");

endmodule

bind hci_acl_connection_credit_tracker hacl_checker u_hacl_checker (.*);

>>> sim/hci_acl_connection_credit_tracker_test.sv
// Self-checking testbench for the HCI ACL connection credit tracker.
`timescale 1ns / 1ps
module hci_acl_connection_credit_tracker_test;
  import hacl_pkg::*;

  localparam int LIMIT_CYCLES = 250000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 228;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 100;
  localparam int SETTLE_CYCLES = 4;

  // One HCI event or host request
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic [FLAGS_W-1:0]  flags;
    logic [AMOUNT_W-1:0] amount;
  } hci_evt_t;

  // Directed plan entry: a register write or an event, optionally with a known beat
  typedef struct {
    bit        is_cfg;
    reg_idx_t  idx;
    logic [CFG_DATA_W-1:0] value;
    hci_evt_t  ev;
    bit        typed;
    result_t   want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic push, full, empty, pop;
  logic [CMD_W-1:0]      in_cmd;
  logic [STATUS_W-1:0]   in_event_status;
  logic [HANDLE_W-1:0]   in_link_handle;
  logic [FLAGS_W-1:0]    in_boundary_flags;
  logic [AMOUNT_W-1:0]   in_amount;
  logic                  out_ok;
  logic [ISSUE_W-1:0]    out_issue_command;
  logic [AMOUNT_W-1:0]   out_acl_header;
  logic [AMOUNT_W-1:0]   out_payload_length;
  logic                  out_is_connected;
  logic [KIND_W-1:0]     out_link_kind;
  logic [AMOUNT_W-1:0]   out_outstanding;
  logic                  out_can_send;
  logic                  out_last;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  hci_acl_connection_credit_tracker uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_cmd(in_cmd), .in_event_status(in_event_status), .in_link_handle(in_link_handle),
    .in_boundary_flags(in_boundary_flags), .in_amount(in_amount),
    .empty(empty), .pop(pop),
    .out_ok(out_ok), .out_issue_command(out_issue_command), .out_acl_header(out_acl_header),
    .out_payload_length(out_payload_length), .out_is_connected(out_is_connected),
    .out_link_kind(out_link_kind), .out_outstanding(out_outstanding),
    .out_can_send(out_can_send), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Tracker shadow state and register copies
  logic                        tr_connected;
  link_t                       tr_kind;
  logic [HANDLE_W-1:0]         tr_handle;
  logic [AMOUNT_W-1:0]         tr_unacked;
  logic [TIMEOUT_W-1:0]        tr_timer;
  logic signed [MODE_W-1:0]    cf_mode;
  logic [CLIMIT_W-1:0]         cf_classic;
  logic [LELIMIT_W-1:0]        cf_le;
  logic [TIMEOUT_W-1:0]        cf_reload;

  result_t   expected_beats[$];
  plan_row_t directed[$];
  result_t   seen_beat, want_beat;
  int        fail_cnt = 0;
  int        sent_cnt = 0;
  int        cycle_cnt = 0;
  bit        gaps_on = 1;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic bit credits_remain();
    if (tr_kind == LINK_CLASSIC && tr_unacked >= cf_classic) return 1'b0;
    if (tr_kind == LINK_LE && tr_unacked >= cf_le) return 1'b0;
    return 1'b1;
  endfunction

  function automatic result_t status_beat(input logic ok, input issue_t iss,
                                          input logic [AMOUNT_W-1:0] hdr,
                                          input logic [AMOUNT_W-1:0] plen,
                                          input logic lst);
    result_t b;
    b.ok             = ok;
    b.issue          = iss;
    b.acl_header     = hdr;
    b.payload_length = plen;
    b.is_connected   = tr_connected;
    b.link_kind      = tr_kind;
    b.outstanding    = tr_unacked;
    b.can_send       = credits_remain();
    b.last           = lst;
    return b;
  endfunction

  function automatic void link_down();
    tr_connected = 1'b0;
    tr_timer     = cf_reload;
    tr_kind      = LINK_NONE;
    tr_handle    = '0;
  endfunction

  function automatic void tracker_reset();
    cf_mode      = HOST_MODE_RESET;
    cf_classic   = '0;
    cf_le        = '0;
    cf_reload    = TIMEOUT_RESET;
    tr_connected = 1'b0;
    tr_kind      = LINK_NONE;
    tr_handle    = '0;
    tr_unacked   = '0;
    tr_timer     = TIMEOUT_RESET;
  endfunction

  function automatic void connect_link(input link_t kind, input logic [HANDLE_W-1:0] h);
    tr_connected = 1'b1;
    tr_timer     = cf_reload;
    tr_kind      = kind;
    tr_handle    = h;
    tr_unacked   = '0;
  endfunction

  // Apply one event to the shadow tracker and queue the beats it produces
  function automatic void track_event(input hci_evt_t e);
    logic                ok;
    issue_t              iss;
    logic [AMOUNT_W-1:0] hdr;
    logic [AMOUNT_W-1:0] plen;
    bit                  two_beats;
    ok = 1'b0;
    iss = ISSUE_NONE;
    hdr = '0;
    plen = '0;
    two_beats = 1'b0;
    case (e.cmd)
      OP_CONN_REQ: iss = tr_connected ? ISSUE_REJECT : ISSUE_ACCEPT;
      OP_CLASSIC_DONE: if (e.status == 0) connect_link(LINK_CLASSIC, e.handle);
      OP_LE_DONE: if (e.status == 0 && !tr_connected) connect_link(LINK_LE, e.handle);
      OP_DISC_DONE: begin
        link_down();
        tr_unacked = '0;
        if (cf_mode == HOST_MODE_OFF) two_beats = 1'b1;
        else iss = (cf_mode > 0) ? ISSUE_ADVERT : ISSUE_SCAN;
      end
      OP_COMPLETED: begin
        tr_timer   = cf_reload;
        tr_unacked = (tr_unacked > e.amount) ? tr_unacked - e.amount : '0;
      end
      OP_SEND: begin
        if (e.amount == 0) begin
          ok = 1'b1;
        end else if (tr_connected && credits_remain()) begin
          ok  = 1'b1;
          hdr = {{(AMOUNT_W-HANDLE_W){1'b0}}, tr_handle} | END_FLAG;
          if (tr_unacked < COUNT_MAX) tr_unacked = tr_unacked + 1'b1;
        end
      end
      OP_RECEIVE: begin
        // only start or complete fragments on the live handle get through
        if (e.flags[1] && tr_connected && e.handle == tr_handle) begin
          ok   = 1'b1;
          plen = (e.amount >= RX_HDR_BYTES) ? e.amount - RX_HDR_BYTES : '0;
        end
      end
      OP_LOCAL_DISC: begin
        iss = ISSUE_DISCONNECT;
        link_down();
      end
      OP_TICK: begin
        if (tr_unacked == 0 || !tr_connected) begin
          tr_timer = cf_reload;
        end else if (tr_timer != 0) begin
          tr_timer = tr_timer - 1'b1;
          if (tr_timer == 0) begin
            iss = ISSUE_DISCONNECT;
            link_down();
          end
        end
      end
      default: ;
    endcase
    if (two_beats) begin
      expected_beats.push_back(status_beat(1'b0, ISSUE_RESET, '0, '0, 1'b0));
      expected_beats.push_back(status_beat(1'b0, ISSUE_SCAN, '0, '0, 1'b1));
    end else begin
      expected_beats.push_back(status_beat(ok, iss, hdr, plen, 1'b1));
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic offer(input hci_evt_t e);
    // random sender gap with push low
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    push              <= 1'b1;
    in_cmd            <= e.cmd;
    in_event_status   <= e.status;
    in_link_handle    <= e.handle;
    in_boundary_flags <= e.flags;
    in_amount         <= e.amount;
    @(posedge clk);
    while (full) @(posedge clk);
    track_event(e);
    sent_cnt++;
  endtask

  // Stop offering and wait until every pending beat has been taken
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_HOST_MODE:     cf_mode    = value[MODE_W-1:0];
      REG_CLASSIC_LIMIT: cf_classic = value[CLIMIT_W-1:0];
      REG_LE_LIMIT:      cf_le      = value[LELIMIT_W-1:0];
      default:           cf_reload  = value[TIMEOUT_W-1:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic plan_row_t ev_row(input logic [CMD_W-1:0] cmd,
                                       input logic [STATUS_W-1:0] st,
                                       input logic [HANDLE_W-1:0] h,
                                       input logic [FLAGS_W-1:0] fl,
                                       input logic [AMOUNT_W-1:0] amt);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = REG_HOST_MODE;
    r.value  = '0;
    r.ev     = '{cmd: cmd, status: st, handle: h, flags: fl, amount: amt};
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    plan_row_t r;
    r = ev_row(OP_NONE, '0, '0, '0, '0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = v;
    return r;
  endfunction

  // Known beat while no link is up and nothing is outstanding
  function automatic plan_row_t unlinked_row(input plan_row_t r, input logic ok,
                                             input issue_t iss);
    r.typed = 1'b1;
    r.want  = '{ok: ok, issue: iss, acl_header: '0, payload_length: '0, is_connected: 1'b0,
                link_kind: LINK_NONE, outstanding: '0, can_send: 1'b1, last: 1'b1};
    return r;
  endfunction

  function automatic logic [15:0] pick_level(input logic [15:0] top, input int span);
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'($urandom_range(2, span));
      default: return top;
    endcase
  endfunction

  // Mostly well-formed traffic around a live link, some noise
  function automatic hci_evt_t random_event();
    hci_evt_t e;
    int r, k;
    e.cmd    = OP_TICK;
    e.status = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    e.handle = ($urandom_range(0, 1) != 0) ? 12'($urandom) : 12'($urandom_range(0, 3));
    e.flags  = 2'($urandom);
    e.amount = 16'($urandom);
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    if (r < 3) begin
      e.cmd = 4'($urandom_range(9, 15));
    end else if (!tr_connected && r < 40) begin
      e.cmd = ($urandom_range(0, 1) != 0) ? OP_CLASSIC_DONE : OP_LE_DONE;
    end else if (k < 30) begin
      e.cmd    = OP_SEND;
      e.amount = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    end else if (k < 55) begin
      e.cmd = OP_TICK;
    end else if (k < 65) begin
      e.cmd    = OP_COMPLETED;
      e.amount = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    end else if (k < 80) begin
      e.cmd    = OP_RECEIVE;
      e.handle = ($urandom_range(0, 3) != 0) ? tr_handle : 12'($urandom);
      e.amount = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 8)) : 16'($urandom);
    end else if (k < 85) begin
      e.cmd = OP_CONN_REQ;
    end else if (k < 89) begin
      e.cmd = OP_DISC_DONE;
    end else if (k < 92) begin
      e.cmd = OP_LOCAL_DISC;
    end else if (k < 96) begin
      e.cmd = OP_CLASSIC_DONE;
    end else begin
      e.cmd = OP_LE_DONE;
    end
    return e;
  endfunction

  // Directed plan: reset behavior, credits, filtering, timeout, disconnect modes
  function automatic void build_directed();
    directed.push_back(unlinked_row(ev_row(OP_CONN_REQ, 8'h00, 12'h000, 2'd0, 16'h0000),
                                    1'b0, ISSUE_ACCEPT));
    directed.push_back(unlinked_row(ev_row(OP_SEND, 8'h00, 12'h000, 2'd0, 16'hFFFF),
                                    1'b0, ISSUE_NONE));
    directed.push_back(unlinked_row(ev_row(OP_SEND, 8'hFF, 12'hFFF, 2'd3, 16'h0000),
                                    1'b1, ISSUE_NONE));
    directed.push_back(unlinked_row(ev_row(OP_NONE, 8'hFF, 12'hFFF, 2'd3, 16'hFFFF),
                                    1'b0, ISSUE_NONE));
    directed.push_back(cfg_row(REG_CLASSIC_LIMIT, 32'd2));
    directed.push_back(cfg_row(REG_LE_LIMIT, 32'hFF));
    directed.push_back(cfg_row(REG_TIMEOUT, 32'd2));
    directed.push_back(ev_row(OP_CLASSIC_DONE, 8'hFF, 12'hFFF, 2'd0, 16'h0000));
    directed.push_back(ev_row(OP_CLASSIC_DONE, 8'h00, 12'hFFF, 2'd0, 16'h0000));
    directed.push_back(ev_row(OP_CONN_REQ, 8'h00, 12'h000, 2'd0, 16'h0000));
    // two sends use up the classic credits, the third is refused
    directed.push_back(ev_row(OP_SEND, 8'h00, 12'h000, 2'd0, 16'hFFFF));
    directed.push_back(ev_row(OP_SEND, 8'h00, 12'h000, 2'd0, 16'h0001));
    directed.push_back(ev_row(OP_SEND, 8'h00, 12'h000, 2'd0, 16'h0001));
    directed.push_back(ev_row(OP_RECEIVE, 8'h00, 12'hFFF, 2'd2, 16'h0003));
    directed.push_back(ev_row(OP_RECEIVE, 8'h00, 12'hFFF, 2'd3, 16'hFFFF));
    directed.push_back(ev_row(OP_RECEIVE, 8'h00, 12'hFFF, 2'd1, 16'h0010));
    // timeout of two ticks forces a disconnect, count survives
    directed.push_back(ev_row(OP_TICK, 8'h00, 12'h000, 2'd0, 16'h0000));
    directed.push_back(ev_row(OP_TICK, 8'h00, 12'h000, 2'd0, 16'h0000));
    directed.push_back(ev_row(OP_COMPLETED, 8'h00, 12'h123, 2'd0, 16'hFFFF));
    directed.push_back(ev_row(OP_LE_DONE, 8'h01, 12'h000, 2'd0, 16'h0000));
    directed.push_back(ev_row(OP_LE_DONE, 8'h00, 12'h000, 2'd0, 16'h0000));
    directed.push_back(ev_row(OP_LE_DONE, 8'h00, 12'h005, 2'd0, 16'h0000));
    directed.push_back(ev_row(OP_SEND, 8'h00, 12'h000, 2'd0, 16'h0010));
    directed.push_back(ev_row(OP_LOCAL_DISC, 8'h00, 12'h000, 2'd0, 16'h0000));
    // disconnection complete under host modes 7 (off), 0, 3 and 4, out-of-range ones too
    directed.push_back(cfg_row(REG_HOST_MODE, 32'd7));
    directed.push_back(ev_row(OP_DISC_DONE, 8'h00, 12'h000, 2'd0, 16'h0000));
    directed.push_back(cfg_row(REG_HOST_MODE, 32'd0));
    directed.push_back(ev_row(OP_DISC_DONE, 8'h00, 12'h000, 2'd0, 16'h0000));
    directed.push_back(cfg_row(REG_HOST_MODE, 32'd3));
    directed.push_back(ev_row(OP_DISC_DONE, 8'h00, 12'h000, 2'd0, 16'h0000));
    directed.push_back(cfg_row(REG_HOST_MODE, 32'd4));
    directed.push_back(ev_row(OP_DISC_DONE, 8'h00, 12'h000, 2'd0, 16'h0000));
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic bit beats_match(input result_t a, input result_t b);
    return a.ok === b.ok && a.issue === b.issue && a.acl_header === b.acl_header &&
           a.payload_length === b.payload_length && a.is_connected === b.is_connected &&
           a.link_kind === b.link_kind && a.outstanding === b.outstanding &&
           a.can_send === b.can_send && a.last === b.last;
  endfunction

  function automatic string beat_text(input result_t b);
    return $sformatf("ok=%0d cmd=%0d hdr=%h len=%h conn=%0d kind=%0d outst=%0d can=%0d last=%0d",
                     b.ok, b.issue, b.acl_header, b.payload_length, b.is_connected,
                     b.link_kind, b.outstanding, b.can_send, b.last);
  endfunction

  // Compare each taken result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      seen_beat.ok             = out_ok;
      seen_beat.issue          = issue_t'(out_issue_command);
      seen_beat.acl_header     = out_acl_header;
      seen_beat.payload_length = out_payload_length;
      seen_beat.is_connected   = out_is_connected;
      seen_beat.link_kind      = link_t'(out_link_kind);
      seen_beat.outstanding    = out_outstanding;
      seen_beat.can_send       = out_can_send;
      seen_beat.last           = out_last;
      if (expected_beats.size() == 0) begin
        if (fail_cnt < 10) $display("unexpected beat: %s", beat_text(seen_beat));
        fail_cnt++;
      end else begin
        want_beat = expected_beats.pop_front();
        if (!beats_match(want_beat, seen_beat)) begin
          if (fail_cnt < 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", beat_text(want_beat));
            $display("  actual   %s", beat_text(seen_beat));
          end
          fail_cnt++;
        end
      end
    end
  end

  // Result side: random pop gaps plus one long hold-off to back up the input
  initial begin
    int  hold_left;
    int  idle_left;
    bit  held_once;
    hold_left = 0;
    idle_left = 0;
    held_once = 1'b0;
    pop = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held_once && sent_cnt >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        pop <= 1'b0;
        idle_left--;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        idle_left = $urandom_range(0, 2);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    int                    ph;
    logic [MODE_W-1:0]     mode_v;
    logic [CLIMIT_W-1:0]   classic_v;
    logic [LELIMIT_W-1:0]  le_v;
    logic [TIMEOUT_W-1:0]  reload_v;
    rst_n             = 1'b0;
    push              = 1'b0;
    in_cmd            = '0;
    in_event_status   = '0;
    in_link_handle    = '0;
    in_boundary_flags = '0;
    in_amount         = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    tracker_reset();
    build_directed();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed plan
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        write_reg(directed[i].idx, directed[i].value);
      end else begin
        offer(directed[i].ev);
        if (directed[i].typed) begin
          void'(expected_beats.pop_back());
          expected_beats.push_back(directed[i].want);
        end
      end
    end

    // random phases, each under its own register settings
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        mode_v = 3'b111; classic_v = 16'hFFFF; le_v = 8'hFF; reload_v = 16'hFFFF;
      end else if (ph == 1) begin
        mode_v = 3'd2; classic_v = 16'd0; le_v = 8'd1; reload_v = 16'd1;
      end else begin
        mode_v    = 3'($urandom_range(0, 7));
        classic_v = pick_level(16'hFFFF, 6);
        le_v      = 8'(pick_level(16'd255, 6));
        reload_v  = pick_level(16'hFFFF, 25);
      end
      write_reg(REG_HOST_MODE, {{(CFG_DATA_W-MODE_W){1'b0}}, mode_v});
      write_reg(REG_CLASSIC_LIMIT, {{(CFG_DATA_W-CLIMIT_W){1'b0}}, classic_v});
      write_reg(REG_LE_LIMIT, {{(CFG_DATA_W-LELIMIT_W){1'b0}}, le_v});
      write_reg(REG_TIMEOUT, {{(CFG_DATA_W-TIMEOUT_W){1'b0}}, reload_v});
      gaps_on = (ph != PHASES - 1);
      repeat (PHASE_ITEMS) offer(random_event());
    end

    settle();
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
